/* hdl/jsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string decoder with UTF-8 checking.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] STATUS_DATA     = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE = 2'd1;
   localparam logic [1:0] STATUS_FAULT    = 2'd2;

   localparam logic [3:0] FAULT_NONE         = 4'd0;
   localparam logic [3:0] FAULT_CONTROL      = 4'd1;
   localparam logic [3:0] FAULT_UNTERMINATED = 4'd2;
   localparam logic [3:0] FAULT_BAD_HEX      = 4'd3;
   localparam logic [3:0] FAULT_BAD_LOW      = 4'd4;
   localparam logic [3:0] FAULT_MISSING_LOW  = 4'd5;
   localparam logic [3:0] FAULT_LONE_LOW     = 4'd6;
   localparam logic [3:0] FAULT_OVERLONG     = 4'd7;
   localparam logic [3:0] FAULT_SURROGATE    = 4'd8;
   localparam logic [3:0] FAULT_ABOVE_MAX    = 4'd9;
   localparam logic [3:0] FAULT_BAD_LEAD     = 4'd10;
   localparam logic [3:0] FAULT_TRUNCATED    = 4'd11;
   localparam logic [3:0] FAULT_BAD_CONT     = 4'd12;

   // All results caused by one request. cnt is 1..4; a status or fault
   // bundle always has cnt 1.
   typedef struct packed {
      logic [2:0]       cnt;
      logic [3:0][7:0]  bytes;
      logic [1:0]       status;
      logic [3:0]       fault;
      logic [15:0]      count;
   } bundle_type;

endpackage

/* hdl/jsu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Decodes one request per cycle while q_full is low and pushes a result bundle.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_byte,
   input  logic        req_ends,
   input  logic        q_full,
   output logic        push,
   output bundle_type  push_data
);

   typedef enum logic [2:0] {
      PH_PLAIN, PH_ESC, PH_HEX1, PH_WANT_BS, PH_WANT_U, PH_HEX2, PH_UTF8, PH_IDLE
   } phase_type;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [15:0]            cp_ff, cp_in;
   logic [9:0]             hh_ff, hh_in;
   logic [2:0]             hl_ff, hl_in;
   logic [2:0][7:0]        seq_ff, seq_in;
   logic [2:0]             exp_ff, exp_in;
   logic [2:0]             seen_ff, seen_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   drop_ff, drop_in;

   logic                   accept;
   phase_type              ph;
   logic [7:0]             b;
   logic [2:0]             k;
   logic [3:0][7:0]        eb;
   logic                   fault_hit;
   logic [3:0]             fcode;
   logic                   done;
   logic                   clr;
   logic                   is_hex;
   logic [3:0]             hval;
   logic [15:0]            hex_cp;
   logic [20:0]            pair_cp;
   logic [34:0]            enc;
   logic [LENGTH_BITS:0]   len_sum;
   logic [31:0]            len_ext;

   function automatic logic [34:0] utf8_encode(input logic [20:0] cp);
      logic [2:0]       n;
      logic [3:0][7:0]  o;
      begin
         o = '0;
         if (cp <= 21'h7F) begin
            n = 3'd1;
            o[0] = cp[7:0];
         end else if (cp <= 21'h7FF) begin
            n = 3'd2;
            o[0] = {3'b110, cp[10:6]};
            o[1] = {2'b10, cp[5:0]};
         end else if (cp <= 21'hFFFF) begin
            n = 3'd3;
            o[0] = {4'b1110, cp[15:12]};
            o[1] = {2'b10, cp[11:6]};
            o[2] = {2'b10, cp[5:0]};
         end else begin
            n = 3'd4;
            o[0] = {5'b11110, cp[20:18]};
            o[1] = {2'b10, cp[17:12]};
            o[2] = {2'b10, cp[11:6]};
            o[3] = {2'b10, cp[5:0]};
         end
         utf8_encode = {n, o};
      end
   endfunction

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;
   assign b = req_byte;
   assign ph = (phase_ff == PH_IDLE) ? PH_PLAIN : phase_ff;

   always_comb begin
      is_hex = 1'b1;
      hval = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hval = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hval = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hval = 4'(b - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign hex_cp = {cp_ff[11:0], hval};
   assign pair_cp = 21'h10000 + {1'b0, hh_ff, hex_cp[9:0]};

   always_comb begin
      phase_in = phase_ff;
      cp_in = cp_ff;
      hh_in = hh_ff;
      hl_in = hl_ff;
      seq_in = seq_ff;
      exp_in = exp_ff;
      seen_in = seen_ff;
      drop_in = drop_ff;
      k = 3'd0;
      eb = '0;
      fault_hit = 1'b0;
      fcode = FAULT_NONE;
      done = 1'b0;
      clr = 1'b0;
      enc = '0;
      if (req_ends) begin
         if (!drop_ff && phase_ff != PH_IDLE) begin
            fault_hit = 1'b1;
            fcode = FAULT_UNTERMINATED;
         end
         clr = 1'b1;
      end else if (!drop_ff) begin
         unique case (ph)
            PH_PLAIN: begin
               phase_in = PH_PLAIN;
               if (b == 8'h22) begin
                  done = 1'b1;
               end else if (b == 8'h5C) begin
                  phase_in = PH_ESC;
               end else if (b <= 8'h1F) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_CONTROL;
               end else if (b < 8'h80) begin
                  k = 3'd1;
                  eb[0] = b;
               end else if (b == 8'hC0 || b == 8'hC1) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_OVERLONG;
               end else if (b >= 8'hF5 && b <= 8'hF7) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_ABOVE_MAX;
               end else if (b < 8'hC2 || b > 8'hF4) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_BAD_LEAD;
               end else begin
                  exp_in = (b <= 8'hDF) ? 3'd2 : ((b <= 8'hEF) ? 3'd3 : 3'd4);
                  seq_in[0] = b;
                  seen_in = 3'd1;
                  phase_in = PH_UTF8;
               end
            end
            PH_ESC: begin
               if (b == 8'h75) begin
                  phase_in = PH_HEX1;
                  hl_in = 3'd4;
                  cp_in = '0;
               end else begin
                  k = 3'd1;
                  unique case (b)
                     8'h62:   eb[0] = 8'h08;
                     8'h66:   eb[0] = 8'h0C;
                     8'h6E:   eb[0] = 8'h0A;
                     8'h72:   eb[0] = 8'h0D;
                     8'h74:   eb[0] = 8'h09;
                     default: eb[0] = b;
                  endcase
                  phase_in = PH_PLAIN;
               end
            end
            PH_HEX1, PH_HEX2: begin
               if (b <= 8'h1F) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_CONTROL;
               end else if (!is_hex) begin
                  fault_hit = 1'b1;
                  fcode = (ph == PH_HEX2) ? FAULT_BAD_LOW : FAULT_BAD_HEX;
               end else if (hl_ff != 3'd1) begin
                  cp_in = hex_cp;
                  hl_in = hl_ff - 3'd1;
               end else begin
                  cp_in = '0;
                  hl_in = 3'd0;
                  if (ph == PH_HEX2) begin
                     if (hex_cp < 16'hDC00 || hex_cp > 16'hDFFF) begin
                        fault_hit = 1'b1;
                        fcode = FAULT_BAD_LOW;
                     end else begin
                        enc = utf8_encode(pair_cp);
                        hh_in = '0;
                        phase_in = PH_PLAIN;
                     end
                  end else if (hex_cp >= 16'hD800 && hex_cp <= 16'hDBFF) begin
                     hh_in = hex_cp[9:0];
                     phase_in = PH_WANT_BS;
                  end else if (hex_cp >= 16'hDC00 && hex_cp <= 16'hDFFF) begin
                     fault_hit = 1'b1;
                     fcode = FAULT_LONE_LOW;
                  end else begin
                     enc = utf8_encode({5'd0, hex_cp});
                     phase_in = PH_PLAIN;
                  end
                  k = enc[34:32];
                  eb = enc[31:0];
               end
            end
            PH_WANT_BS: begin
               if (b <= 8'h1F) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_CONTROL;
               end else if (b != 8'h5C) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_MISSING_LOW;
               end else begin
                  phase_in = PH_WANT_U;
               end
            end
            PH_WANT_U: begin
               if (b != 8'h75) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_MISSING_LOW;
               end else begin
                  phase_in = PH_HEX2;
                  hl_in = 3'd4;
                  cp_in = '0;
               end
            end
            PH_UTF8: begin
               if (b <= 8'h1F) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_CONTROL;
               end else if (b == 8'h22) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_TRUNCATED;
               end else if (seen_ff == 3'd1 && seq_ff[0] == 8'hE0 && b < 8'hA0) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_OVERLONG;
               end else if (seen_ff == 3'd1 && seq_ff[0] == 8'hED && b >= 8'hA0) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_SURROGATE;
               end else if (seen_ff == 3'd1 && seq_ff[0] == 8'hF0 && b < 8'h90) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_OVERLONG;
               end else if (seen_ff == 3'd1 && seq_ff[0] == 8'hF4 && b >= 8'h90) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_ABOVE_MAX;
               end else if (b[7:6] != 2'b10) begin
                  fault_hit = 1'b1;
                  fcode = FAULT_BAD_CONT;
               end else if (seen_ff + 3'd1 >= exp_ff) begin
                  k = exp_ff;
                  for (int i = 0; i < 3; i++) begin
                     if (3'(i) < seen_ff) begin
                        eb[i] = seq_ff[i];
                     end else if (3'(i) == seen_ff) begin
                        eb[i] = b;
                     end
                  end
                  if (seen_ff == 3'd3) begin
                     eb[3] = b;
                  end
                  seq_in = '0;
                  exp_in = 3'd0;
                  seen_in = 3'd0;
                  phase_in = PH_PLAIN;
               end else begin
                  seq_in[seen_ff[1:0]] = b;
                  seen_in = seen_ff + 3'd1;
               end
            end
            default: begin
               clr = 1'b1;
            end
         endcase
         if (fault_hit) begin
            clr = 1'b1;
            drop_in = 1'b1;
         end
         if (done) begin
            clr = 1'b1;
         end
      end else begin
         clr = 1'b0;
      end
      if (req_ends) begin
         drop_in = 1'b0;
      end
   end

   assign len_sum = {1'b0, len_ff} + (LENGTH_BITS + 1)'(k);
   assign len_ext = 32'(len_ff);

   always_comb begin
      len_in = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];
      if (clr) begin
         len_in = '0;
      end
   end

   always_comb begin
      push = accept && (k != 3'd0 || fault_hit || done);
      push_data = '0;
      if (fault_hit) begin
         push_data.cnt = 3'd1;
         push_data.status = STATUS_FAULT;
         push_data.fault = fcode;
      end else if (done) begin
         push_data.cnt = 3'd1;
         push_data.status = STATUS_COMPLETE;
         push_data.count = len_ext[15:0];
      end else begin
         push_data.cnt = k;
         push_data.bytes = eb;
         push_data.status = STATUS_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         cp_ff <= '0;
         hh_ff <= '0;
         hl_ff <= '0;
         seq_ff <= '0;
         exp_ff <= '0;
         seen_ff <= '0;
         len_ff <= '0;
         drop_ff <= 1'b0;
      end else if (accept) begin
         if (clr) begin
            phase_ff <= done ? PH_IDLE : PH_PLAIN;
            cp_ff <= '0;
            hh_ff <= '0;
            hl_ff <= '0;
            seq_ff <= '0;
            exp_ff <= '0;
            seen_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            cp_ff <= cp_in;
            hh_ff <= hh_in;
            hl_ff <= hl_in;
            seq_ff <= seq_in;
            exp_ff <= exp_in;
            seen_ff <= seen_in;
         end
         len_ff <= len_in;
         drop_ff <= drop_in;
      end
   end

endmodule

/* hdl/jsu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of result bundles between the decoder and the output stage.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type head,
   output logic       empty
);

   bundle_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ff, rd_ff;
   logic [QUEUE_PTR_BITS:0]    count_ff;

   assign full = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

/* hdl/jsu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Walks the bundle at the head of the queue out as single result items.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bundle_type  head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic [1:0] idx_ff;
   logic       final_item;

   assign rsp_tvalid = !empty;
   assign final_item = (idx_ff == 2'(head.cnt - 3'd1));
   assign rsp_tlast = final_item;
   assign rsp_tdata = {2'b00, head.count, head.fault, head.status, head.bytes[idx_ff]};
   assign pop = rsp_tvalid && rsp_tready && final_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         idx_ff <= final_item ? 2'd0 : idx_ff + 2'd1;
      end
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, idx_ff} < head.cnt))
      else $error("result index past bundle size");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(idx_ff))
      else $error("result index moved while stalled");

endmodule

/* hdl/json_string_unescape_utf8_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check
// JSON string body decoder with escape handling and UTF-8 validation.
// ----------------------------------------------------------------------------
// The block takes one byte of a JSON string body per request, every cycle,
// as long as its four-entry result queue has room; each request yields zero
// to four results, which leave the output port at one per cycle while
// rsp_tready is high. A request that completes a UTF-8 sequence or a \u
// escape releases all its bytes at once, so a run of such requests is paced
// by the output port. There is no clearing pass after reset.
module json_string_unescape_utf8_check import jsu_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // input_ends
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [9:8] status,
                                    // [13:10] fault_code, [29:14] byte_count
   output logic        rsp_tlast    // last
);

   logic       q_full;
   logic       q_empty;
   logic       push;
   logic       pop;
   bundle_type push_data;
   bundle_type head;

   jsu_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_ends   (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
